>>> rtl/core/pfrwl_pkg.sv
`default_nettype none

package pfrwl_pkg;

   localparam int ID_PORT_W   = 16;
   localparam int STATUS_W    = 3;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic CMD_SUBMIT  = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_FULL    = 3'd2,
      ST_PENDING = 3'd3,
      ST_EMPTY   = 3'd4,
      ST_IDLE    = 3'd5,
      ST_GRANT   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUB,
      S_REL_HEAD,
      S_REL_NEXT,
      S_GRANT
   } state_type;

   // one generation: exclusive flag, active holders, waiters in the store
   typedef struct packed {
      logic             excl;
      logic [CNT_W-1:0] active;
      logic [CNT_W-1:0] count;
   } gen_rec_type;

   typedef struct packed {
      logic       accept;
      logic       rd_tail;
      logic       rd_head;
      logic       rd_next;
      logic       open_gen;
      logic       join_gen;
      logic       dec_active;
      logic       advance;
      logic       start_grants;
      logic       next_grant;
      logic       emit;
      logic       emit_grant;
      status_type emit_code;
   } cmd_type;

   typedef struct packed {
      logic gen_empty;
      logic gen_single;
      logic gen_full;
      logic waiter_full;
      logic tail_joinable;
      logic tail_capped;
      logic release_zero;
      logic grant_none;
      logic grant_final;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/core/pfrwl_ctrl.sv
`default_nettype none

module pfrwl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_command,
   input  wire pfrwl_pkg::stat_type stat,
   output pfrwl_pkg::cmd_type      cmd,
   output logic                    busy
);
   import pfrwl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.emit_code = ST_GRANTED;
      state_in  = state_ff;
      busy      = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_command == CMD_RELEASE) begin
                  cmd.rd_head = 1'b1;
                  state_in    = S_REL_HEAD;
               end else begin
                  cmd.rd_tail = 1'b1;
                  state_in    = S_SUB;
               end
            end
         end
         S_SUB: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
            if (stat.gen_empty) begin
               if (stat.waiter_full) begin
                  cmd.emit_code = ST_FULL;
               end else begin
                  cmd.open_gen  = 1'b1;
                  cmd.emit_code = ST_GRANTED;
               end
            end else if (stat.tail_joinable) begin
               if (stat.waiter_full || stat.tail_capped) begin
                  cmd.emit_code = ST_FULL;
               end else begin
                  cmd.join_gen  = 1'b1;
                  cmd.emit_code = stat.gen_single ? ST_GRANTED : ST_QUEUED;
               end
            end else if (stat.waiter_full || stat.gen_full) begin
               cmd.emit_code = ST_FULL;
            end else begin
               cmd.open_gen  = 1'b1;
               cmd.emit_code = ST_QUEUED;
            end
         end
         S_REL_HEAD: begin
            state_in = S_IDLE;
            if (stat.gen_empty) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = ST_EMPTY;
            end else if (!stat.release_zero) begin
               cmd.dec_active = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_code  = ST_PENDING;
            end else begin
               cmd.advance = 1'b1;
               if (stat.gen_single) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_code = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = S_REL_NEXT;
               end
            end
         end
         S_REL_NEXT: begin
            if (stat.grant_none) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = ST_IDLE;
               state_in      = S_IDLE;
            end else begin
               cmd.start_grants = 1'b1;
               state_in         = S_GRANT;
            end
         end
         S_GRANT: begin
            cmd.emit       = 1'b1;
            cmd.emit_grant = 1'b1;
            cmd.emit_code  = ST_GRANT;
            if (stat.grant_final) begin
               state_in = S_IDLE;
            end else begin
               cmd.next_grant = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/pfrwl_dp.sv
`default_nettype none

module pfrwl_dp #(
   parameter int WAITER_SLOTS = 32,
   parameter int GEN_SLOTS    = 32,
   parameter int ID_WIDTH     = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pfrwl_pkg::cmd_type              cmd,
   input  wire logic [pfrwl_pkg::ID_PORT_W-1:0] req_request_id,
   input  wire logic                            req_is_exclusive,
   output pfrwl_pkg::stat_type                  stat,
   output logic                                 rsp_valid,
   output logic [pfrwl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pfrwl_pkg::ID_PORT_W-1:0]      rsp_grant_id,
   output logic                                 rsp_last
);
   import pfrwl_pkg::*;

   localparam int IDW  = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W;
   localparam int WP   = $clog2(WAITER_SLOTS);
   localparam int GP   = $clog2(GEN_SLOTS);
   localparam int WOW  = $clog2(WAITER_SLOTS + 1);
   localparam int GOW  = $clog2(GEN_SLOTS + 1);
   localparam int WSUM = WP + 1;
   localparam int CW   = (CNT_W > WOW) ? CNT_W : WOW;

   // stores
   logic [IDW-1:0] waiter_mem [WAITER_SLOTS];
   gen_rec_type    gen_mem    [GEN_SLOTS];

   logic [IDW-1:0] waiter_rd_ff;
   gen_rec_type    gen_rd_ff;

   logic [IDW-1:0] id_ff;
   logic           excl_ff;

   logic [WP-1:0]  waiter_rd_ptr_ff, waiter_rd_ptr_in;
   logic [WP-1:0]  waiter_wr_ptr_ff, waiter_wr_ptr_in;
   logic [WOW-1:0] waiter_occ_ff,    waiter_occ_in;
   logic [GP-1:0]  gen_rd_ptr_ff,    gen_rd_ptr_in;
   logic [GP-1:0]  gen_wr_ptr_ff,    gen_wr_ptr_in;
   logic [GOW-1:0] gen_occ_ff,       gen_occ_in;
   logic [WP-1:0]  grant_addr_ff,    grant_addr_in;
   logic [CNT_W-1:0] remain_ff,      remain_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [ID_PORT_W-1:0]  rsp_grant_id_ff;
   logic                  rsp_last_ff;

   logic [GP-1:0]    tail_addr;
   logic [GP-1:0]    gen_rd_next;
   logic [GP-1:0]    gen_wr_next;
   logic [GP-1:0]    gen_addr_rd;
   logic             gen_re;
   logic [GP-1:0]    gen_addr_wr;
   logic             gen_we;
   gen_rec_type      gen_wdata;
   logic [WP-1:0]    waiter_addr_rd;
   logic             waiter_re;
   logic             push_waiter;
   logic [CNT_W-1:0] n_drop;
   logic [CNT_W-1:0] n_avail;
   logic [CNT_W-1:0] n_grant;
   logic [WSUM-1:0]  drop_sum;
   logic [WSUM-1:0]  drop_wrap;

   always_comb begin
      tail_addr   = (gen_wr_ptr_ff == '0) ? GP'(GEN_SLOTS - 1) : gen_wr_ptr_ff - 1'b1;
      gen_rd_next = (gen_rd_ptr_ff == GP'(GEN_SLOTS - 1)) ? '0 : gen_rd_ptr_ff + 1'b1;
      gen_wr_next = (gen_wr_ptr_ff == GP'(GEN_SLOTS - 1)) ? '0 : gen_wr_ptr_ff + 1'b1;

      n_drop  = (CW'(gen_rd_ff.count) > CW'(waiter_occ_ff)) ? CNT_W'(waiter_occ_ff)
                                                            : gen_rd_ff.count;
      n_avail = n_drop;
      n_grant = (n_avail > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : n_avail;

      drop_sum  = WSUM'(waiter_rd_ptr_ff) + WSUM'(n_drop);
      drop_wrap = (drop_sum >= WSUM'(WAITER_SLOTS)) ? drop_sum - WSUM'(WAITER_SLOTS)
                                                    : drop_sum;
   end

   // status towards the controller
   always_comb begin
      stat.gen_empty     = (gen_occ_ff == '0);
      stat.gen_single    = (gen_occ_ff == GOW'(1));
      stat.gen_full      = (gen_occ_ff == GOW'(GEN_SLOTS));
      stat.waiter_full   = (waiter_occ_ff == WOW'(WAITER_SLOTS));
      stat.tail_joinable = !excl_ff && !gen_rd_ff.excl;
      stat.tail_capped   = (gen_rd_ff.count >= CNT_W'(MAX_RESULTS));
      stat.release_zero  = (gen_rd_ff.active <= CNT_W'(1));
      stat.grant_none    = (n_grant == '0);
      stat.grant_final   = (remain_ff == CNT_W'(1));
   end

   // generation store ports
   always_comb begin
      gen_re      = cmd.rd_tail | cmd.rd_head | cmd.rd_next;
      gen_addr_rd = gen_rd_ptr_ff;
      if (cmd.rd_tail) begin
         gen_addr_rd = tail_addr;
      end else if (cmd.rd_next) begin
         gen_addr_rd = gen_rd_next;
      end

      gen_we      = cmd.open_gen | cmd.join_gen | cmd.dec_active;
      gen_addr_wr = gen_wr_ptr_ff;
      gen_wdata   = '{excl: excl_ff, active: CNT_W'(1), count: CNT_W'(1)};
      if (cmd.join_gen) begin
         gen_addr_wr = tail_addr;
         gen_wdata   = '{excl:   gen_rd_ff.excl,
                         active: gen_rd_ff.active + 1'b1,
                         count:  gen_rd_ff.count + 1'b1};
      end else if (cmd.dec_active) begin
         gen_addr_wr = gen_rd_ptr_ff;
         gen_wdata   = '{excl:   gen_rd_ff.excl,
                         active: gen_rd_ff.active - 1'b1,
                         count:  gen_rd_ff.count};
      end
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_addr_wr] <= gen_wdata;
      end
      if (gen_re) begin
         gen_rd_ff <= gen_mem[gen_addr_rd];
      end
   end

   // waiter store ports
   always_comb begin
      push_waiter    = cmd.open_gen | cmd.join_gen;
      waiter_re      = cmd.start_grants | cmd.next_grant;
      waiter_addr_rd = cmd.start_grants ? waiter_rd_ptr_ff : grant_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (push_waiter) begin
         waiter_mem[waiter_wr_ptr_ff] <= id_ff;
      end
      if (waiter_re) begin
         waiter_rd_ff <= waiter_mem[waiter_addr_rd];
      end
      if (cmd.accept) begin
         id_ff   <= req_request_id[IDW-1:0];
         excl_ff <= req_is_exclusive;
      end
   end

   // pointers and occupancy
   always_comb begin
      waiter_rd_ptr_in = waiter_rd_ptr_ff;
      waiter_wr_ptr_in = waiter_wr_ptr_ff;
      waiter_occ_in    = waiter_occ_ff;
      gen_rd_ptr_in    = gen_rd_ptr_ff;
      gen_wr_ptr_in    = gen_wr_ptr_ff;
      gen_occ_in       = gen_occ_ff;
      grant_addr_in    = grant_addr_ff;
      remain_in        = remain_ff;
      if (push_waiter) begin
         waiter_wr_ptr_in = (waiter_wr_ptr_ff == WP'(WAITER_SLOTS - 1)) ? '0
                                                         : waiter_wr_ptr_ff + 1'b1;
         waiter_occ_in    = waiter_occ_ff + 1'b1;
      end
      if (cmd.open_gen) begin
         gen_wr_ptr_in = gen_wr_next;
         gen_occ_in    = gen_occ_ff + 1'b1;
      end
      if (cmd.advance) begin
         waiter_rd_ptr_in = drop_wrap[WP-1:0];
         waiter_occ_in    = waiter_occ_ff - WOW'(n_drop);
         gen_rd_ptr_in    = gen_rd_next;
         gen_occ_in       = gen_occ_ff - 1'b1;
      end
      if (waiter_re) begin
         grant_addr_in = (waiter_addr_rd == WP'(WAITER_SLOTS - 1)) ? '0
                                                         : waiter_addr_rd + 1'b1;
      end
      if (cmd.start_grants) begin
         remain_in = n_grant;
      end else if (cmd.next_grant) begin
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiter_rd_ptr_ff <= '0;
         waiter_wr_ptr_ff <= '0;
         waiter_occ_ff    <= '0;
         gen_rd_ptr_ff    <= '0;
         gen_wr_ptr_ff    <= '0;
         gen_occ_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         waiter_rd_ptr_ff <= waiter_rd_ptr_in;
         waiter_wr_ptr_ff <= waiter_wr_ptr_in;
         waiter_occ_ff    <= waiter_occ_in;
         gen_rd_ptr_ff    <= gen_rd_ptr_in;
         gen_wr_ptr_ff    <= gen_wr_ptr_in;
         gen_occ_ff       <= gen_occ_in;
         rsp_valid_ff     <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      grant_addr_ff <= grant_addr_in;
      remain_ff     <= remain_in;
      if (cmd.emit) begin
         rsp_status_ff   <= cmd.emit_code;
         rsp_grant_id_ff <= cmd.emit_grant ? ID_PORT_W'(waiter_rd_ff) : '0;
         rsp_last_ff     <= !cmd.emit_grant || (remain_ff == CNT_W'(1));
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_grant_id = rsp_grant_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/phase_fair_rw_lock_queue.sv
`default_nettype none

// Phase-fair reader/writer lock queue. Pulse start with a transaction on the
// req_ ports while busy is low: a submit (req_command 0) places the request in
// the generation queue or reports full, a release (req_command 1) retires one
// holder of the head generation or reports empty. Results appear on the rsp_
// ports for exactly one cycle, marked by rsp_valid; the receiver cannot stall,
// so it must take every result as it comes. A submit, a release that does not
// drain the head, and a release that drains the last generation each read the
// generation record through the registered read port of its store and then
// update it before the next accept. A release that drains the head and
// advances to a further generation then reads the new head and streams the
// waiters to grant out of the waiter store one per cycle through its single
// read port, each grant leaving on its own cycle. Results are registered
// before they reach the ports, so they may still be leaving while the next
// transaction is accepted. Both stores come out of reset usable at once: no
// clearing pass.

module phase_fair_rw_lock_queue #(
   parameter int WAITER_SLOTS = 32,
   parameter int GEN_SLOTS    = 32,
   parameter int ID_WIDTH     = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_command,
   input  wire logic [pfrwl_pkg::ID_PORT_W-1:0] req_request_id,
   input  wire logic                            req_is_exclusive,
   output logic                                 rsp_valid,
   output logic [pfrwl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pfrwl_pkg::ID_PORT_W-1:0]      rsp_grant_id,
   output logic                                 rsp_last
);
   import pfrwl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence each transaction: read the record, decide, stream grants
   pfrwl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   // hold the waiter and generation stores, their pointers and the result register
   pfrwl_dp #(
      .WAITER_SLOTS (WAITER_SLOTS),
      .GEN_SLOTS    (GEN_SLOTS),
      .ID_WIDTH     (ID_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_request_id   (req_request_id),
      .req_is_exclusive (req_is_exclusive),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_grant_id     (rsp_grant_id),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
